@@ design/wao_pkg.sv @@
// Package for the windowed alpha overlay blend: word types, register indexes, constants.
// No dependencies; every module of the block imports it.
package wao_pkg;

	localparam int NUM_LANES = 4;
	localparam int CH_W      = 8;
	localparam int CFG_W     = 12;
	localparam int IDX_W     = 8;
	localparam int POS_W     = 11;

	localparam logic [CH_W-1:0] CH_MAX = 8'd255;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_LEFT   = 8'd0;
	localparam logic [IDX_W-1:0] REG_TOP    = 8'd1;
	localparam logic [IDX_W-1:0] REG_WIDTH  = 8'd2;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 8'd3;

	typedef struct packed {
		logic [POS_W-1:0] pix_col;
		logic [POS_W-1:0] pix_row;
		logic [CH_W-1:0]  bg_ch0;
		logic [CH_W-1:0]  bg_ch1;
		logic [CH_W-1:0]  bg_ch2;
		logic [CH_W-1:0]  bg_ch3;
		logic [CH_W-1:0]  ov_ch0;
		logic [CH_W-1:0]  ov_ch1;
		logic [CH_W-1:0]  ov_ch2;
		logic [CH_W-1:0]  ov_alpha;
	} wao_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_ch0;
		logic [CH_W-1:0] out_ch1;
		logic [CH_W-1:0] out_ch2;
		logic [CH_W-1:0] out_ch3;
		logic            inside_window;
	} wao_out_t;

	typedef struct packed {
		logic signed [CFG_W-1:0] left;
		logic signed [CFG_W-1:0] top;
		logic [CFG_W-1:0]        width;
		logic [CFG_W-1:0]        height;
	} wao_cfg_t;

	typedef struct packed {
		logic en;
		logic blend;
	} wao_lane_ctl_t;

endpackage

@@ design/wao_window.sv @@
// Window membership test of one pixel position against the overlay rectangle.
// Depends on wao_pkg.
module wao_window import wao_pkg::*; (
	input  logic [POS_W-1:0] pix_col,
	input  logic [POS_W-1:0] pix_row,
	input  wao_cfg_t         cfg,
	output logic             hit
);

	logic signed [CFG_W:0] dx;
	logic signed [CFG_W:0] dy;

	assign dx = $signed({2'b00, pix_col}) - $signed({cfg.left[CFG_W-1], cfg.left});
	assign dy = $signed({2'b00, pix_row}) - $signed({cfg.top[CFG_W-1], cfg.top});

	// non-negative offset, below the count
	assign hit = !dx[CFG_W] && (dx[CFG_W-1:0] < cfg.width) &&
	             !dy[CFG_W] && (dy[CFG_W-1:0] < cfg.height);

endmodule

@@ design/wao_lane.sv @@
// One blend lane: weighted sum of background and overlay, then exact divide by 255.
// Depends on wao_pkg.
module wao_lane import wao_pkg::*; (
	input  logic            clk,
	input  wao_lane_ctl_t   ctl,
	input  logic [CH_W-1:0] bg,
	input  logic [CH_W-1:0] ov,
	input  logic [CH_W-1:0] alpha,
	output logic [CH_W-1:0] result
);

	logic [2*CH_W-1:0] num;
	logic [2*CH_W-1:0] num_s2;
	logic [CH_W-1:0]   bg_s2;
	logic              blend_s2;
	logic [2*CH_W:0]   quot_t;

	assign num = {{CH_W{1'b0}}, bg} * {{CH_W{1'b0}}, CH_MAX - alpha}
	           + {{CH_W{1'b0}}, ov} * {{CH_W{1'b0}}, alpha};

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			num_s2   <= num;
			bg_s2    <= bg;
			blend_s2 <= ctl.blend;
		end
	end

	// floor(n / 255) for n up to 255*255: (n + 1 + (n >> 8)) >> 8
	assign quot_t = {1'b0, num_s2} + {{2*CH_W{1'b0}}, 1'b1}
	              + {{CH_W+1{1'b0}}, num_s2[2*CH_W-1:CH_W]};

	assign result = blend_s2 ? quot_t[2*CH_W-1:CH_W] : bg_s2;

endmodule

@@ design/wao_merge.sv @@
// Merge stage: gathers the lane results and the window flag into the output register.
// Depends on wao_pkg.
module wao_merge import wao_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           valid_s2,
	input  logic                           inside_s2,
	input  logic [NUM_LANES-1:0][CH_W-1:0] lane_result,
	output logic                           out_valid,
	output wao_out_t                       out_word
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word.out_ch0       <= lane_result[0];
			out_word.out_ch1       <= lane_result[1];
			out_word.out_ch2       <= lane_result[2];
			out_word.out_ch3       <= lane_result[3];
			out_word.inside_window <= inside_s2;
		end
	end

endmodule

@@ design/windowed_alpha_overlay_blend.sv @@
// Top level of the windowed alpha overlay blend: config registers, pipeline control, lanes.
// Depends on wao_pkg, wao_window, wao_lane and wao_merge.
//
// Usage:
//   Input channel (in_valid / in_stall / in_word) carries one background pixel, its
//   raster position and the matching overlay pixel. Output channel (out_valid /
//   out_stall / out_word) returns the four blended channels and the window flag.
//   A word moves when valid is high and stall is low at a rising edge of clk.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the overlay
//   left, top, width and height registers; cfg_ready is always high and writes to
//   an index above 3 are dropped. Write configuration only while the block is idle.
//   An accepted input word passes the input stage with window test, the lane multiply
//   stage and the merge output register before its output word is valid.
//   Throughput: one word per cycle while out_stall is low; four lanes blend the four
//   channels of a word side by side, so the lane multipliers set that rate.
//   Stall: each stage advances when it is empty or the stage after it advances, so
//   bubbles collapse and new words are still taken while a finished word waits.
//   A full pipeline behind a stalled output holds and raises in_stall.
//   Reset (arst_n low): all stages empty, config registers cleared to zero (empty window).
module windowed_alpha_overlay_blend import wao_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  wao_in_t           in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output wao_out_t          out_word,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	wao_cfg_t cfg_q;

	logic    en_out;
	logic    en_s2;
	logic    en_s1;
	logic    valid_s1;
	logic    valid_s2;
	logic    win_hit;
	logic    inside_s1;
	logic    inside_s2;
	wao_in_t word_s1;

	wao_lane_ctl_t                  lane_ctl;
	logic [NUM_LANES-1:0][CH_W-1:0] lane_bg;
	logic [NUM_LANES-1:0][CH_W-1:0] lane_ov;
	logic [NUM_LANES-1:0][CH_W-1:0] lane_result;

	// Configuration registers: always ready, unknown indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LEFT:   cfg_q.left   <= cfg_data;
				REG_TOP:    cfg_q.top    <= cfg_data;
				REG_WIDTH:  cfg_q.width  <= cfg_data;
				REG_HEIGHT: cfg_q.height <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Stage enables: a stage advances when empty or when its successor advances
	assign en_out   = !out_valid || !out_stall;
	assign en_s2    = !valid_s2 || en_out;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// Stage 1: take the input word and its window flag
	wao_window u_window (
		.pix_col (in_word.pix_col),
		.pix_row (in_word.pix_row),
		.cfg     (cfg_q),
		.hit     (win_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			word_s1   <= in_word;
			inside_s1 <= win_hit;
		end
		if (en_s2) begin
			inside_s2 <= inside_s1;
		end
	end

	// Stage 2: one lane per channel; the alpha channel blends against alpha itself
	assign lane_ctl.en    = en_s2;
	assign lane_ctl.blend = inside_s1 && (word_s1.ov_alpha != '0);

	assign lane_bg[0] = word_s1.bg_ch0;
	assign lane_bg[1] = word_s1.bg_ch1;
	assign lane_bg[2] = word_s1.bg_ch2;
	assign lane_bg[3] = word_s1.bg_ch3;
	assign lane_ov[0] = word_s1.ov_ch0;
	assign lane_ov[1] = word_s1.ov_ch1;
	assign lane_ov[2] = word_s1.ov_ch2;
	assign lane_ov[3] = word_s1.ov_alpha;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		wao_lane u_lane (
			.clk    (clk),
			.ctl    (lane_ctl),
			.bg     (lane_bg[i]),
			.ov     (lane_ov[i]),
			.alpha  (word_s1.ov_alpha),
			.result (lane_result[i])
		);
	end

	// Stage 3: merge lanes into the output register
	wao_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en_out),
		.valid_s2    (valid_s2),
		.inside_s2   (inside_s2),
		.lane_result (lane_result),
		.out_valid   (out_valid),
		.out_word    (out_word)
	);

endmodule

@@ tb/sv/tb_windowed_alpha_overlay_blend.sv @@
`timescale 1ns / 1ps
// Testbench for windowed_alpha_overlay_blend: pixel words are streamed through a series
// of overlay windows, and each output word is checked against a local blend predictor.
// Depends on wao_pkg and the block's RTL only.
module tb_windowed_alpha_overlay_blend;
	import wao_pkg::*;

	localparam int LATENCY     = 3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_PIXELS = 70;
	localparam int MAX_BURST   = 14;
	localparam int MAX_COORD   = (1 << POS_W) - 1;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	wao_in_t          in_word   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	wao_out_t         out_word;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;

	// Pixel words waiting for the driver, and blended words waiting for the output side
	wao_in_t  pixel_q[$];
	wao_out_t blended_q[$];
	// Local copy of the window registers, updated on each accepted register write
	wao_cfg_t win_cfg = '0;
	bit       in_moved;
	int       gap_left, stall_left, gap_pct, stall_pct;
	int       mismatches, cycle_count;

	windowed_alpha_overlay_blend u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Exact integer alpha-over of one channel: floor((bg*(255-a) + ov*a) / 255)
	function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] bg, ov, a);
		int num;
		num = int'(bg) * (int'(CH_MAX) - int'(a)) + int'(ov) * int'(a);
		return CH_W'(num / int'(CH_MAX));
	endfunction

	// Expected output word for one pixel word under the given window
	function automatic wao_out_t blend_pixel(wao_in_t px, wao_cfg_t w);
		int       dx, dy;
		logic     hit, mixing;
		wao_out_t r;
		// Offsets are signed; width and height compare as plain 12-bit counts,
		// so a zero size never hits and sizes above 2048 are taken as written.
		dx = int'(px.pix_col) - int'($signed(w.left));
		dy = int'(px.pix_row) - int'($signed(w.top));
		hit = dx >= 0 && dx < int'(w.width) && dy >= 0 && dy < int'(w.height);
		// Zero opacity passes the background even inside the window
		mixing = hit && px.ov_alpha != '0;
		r.out_ch0 = mixing ? mix_channel(px.bg_ch0, px.ov_ch0, px.ov_alpha) : px.bg_ch0;
		r.out_ch1 = mixing ? mix_channel(px.bg_ch1, px.ov_ch1, px.ov_alpha) : px.bg_ch1;
		r.out_ch2 = mixing ? mix_channel(px.bg_ch2, px.ov_ch2, px.ov_alpha) : px.bg_ch2;
		// Channel 3 blends the background alpha with the overlay alpha itself
		r.out_ch3 = mixing ? mix_channel(px.bg_ch3, px.ov_alpha, px.ov_alpha) : px.bg_ch3;
		r.inside_window = hit;
		return r;
	endfunction

	// Channel values lean toward the extremes
	function automatic logic [CH_W-1:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom);
		endcase
	endfunction

	// Coordinates mostly land on or just around the window so that edges get hit;
	// the rest spread over the whole raster. Clamping makes 0 and the top common.
	function automatic logic [POS_W-1:0] pick_coord(int origin, int span);
		int v;
		if ($urandom_range(0, 4) == 0)
			v = $urandom_range(0, MAX_COORD);
		else
			v = origin - 2 + int'($urandom_range(0, span + 3));
		if (v < 0)
			v = 0;
		if (v > MAX_COORD)
			v = MAX_COORD;
		return POS_W'(v);
	endfunction

	function automatic wao_in_t random_pixel(wao_cfg_t w);
		wao_in_t px;
		px.pix_col  = pick_coord(int'($signed(w.left)), int'(w.width));
		px.pix_row  = pick_coord(int'($signed(w.top)), int'(w.height));
		px.bg_ch0   = pick_byte();
		px.bg_ch1   = pick_byte();
		px.bg_ch2   = pick_byte();
		px.bg_ch3   = pick_byte();
		px.ov_ch0   = pick_byte();
		px.ov_ch1   = pick_byte();
		px.ov_ch2   = pick_byte();
		px.ov_alpha = pick_byte();
		return px;
	endfunction

	function automatic wao_in_t make_pixel(int col, int row, logic [CH_W-1:0] bg, ov, a);
		wao_in_t px;
		px.pix_col  = POS_W'(col);
		px.pix_row  = POS_W'(row);
		px.bg_ch0   = bg;
		px.bg_ch1   = bg;
		px.bg_ch2   = bg;
		px.bg_ch3   = bg;
		px.ov_ch0   = ov;
		px.ov_ch1   = ov;
		px.ov_ch2   = ov;
		px.ov_alpha = a;
		return px;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// One register write; hold the word until cfg_ready takes it
	task automatic write_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Block until every queued pixel word is in and every blended word is out,
	// then let the pipeline settle
	task automatic wait_drained();
		do @(posedge clk); while (pixel_q.size() != 0 || in_valid || blended_q.size() != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Program a window, drop a write to an unused index, then stream random pixels
	task automatic run_window(logic [CFG_W-1:0] left, top, width, height, int pixels, int pct);
		write_reg(REG_LEFT, left);
		write_reg(REG_TOP, top);
		write_reg(REG_WIDTH, width);
		write_reg(REG_HEIGHT, height);
		write_reg(IDX_W'($urandom_range(int'(REG_HEIGHT) + 1, (1 << IDX_W) - 1)),
			CFG_W'($urandom));
		gap_pct   = pct;
		stall_pct = pct;
		repeat (pixels)
			pixel_q.push_back(random_pixel(win_cfg));
		wait_drained();
	endtask

	// Input driver: advance at the falling edge. A stalled word stays put; otherwise
	// either idle for the rest of a gap burst or present the next queued word.
	always @(negedge clk) begin : pixel_driver
		if (!in_valid || in_moved) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pixel_q.size() != 0) begin
				in_word  <= pixel_q.pop_front();
				in_valid <= 1'b1;
				if ($urandom_range(0, 99) < gap_pct)
					gap_left = $urandom_range(1, MAX_BURST);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output back-pressure: stall in random bursts
	always @(negedge clk) begin : stall_driver
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, MAX_BURST);
		end
	end

	// Monitor: sample at the rising edge. Predict on every accepted pixel word,
	// track register writes, and check every accepted output word in order.
	always @(posedge clk) begin : blend_monitor
		wao_out_t want;
		in_moved = arst_n && in_valid && !in_stall;
		if (in_moved)
			blended_q.push_back(blend_pixel(in_word, win_cfg));
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEFT:   win_cfg.left   = cfg_data;
				REG_TOP:    win_cfg.top    = cfg_data;
				REG_WIDTH:  win_cfg.width  = cfg_data;
				REG_HEIGHT: win_cfg.height = cfg_data;
				default: ;
			endcase
		end
		if (arst_n && out_valid && !out_stall) begin
			if (blended_q.size() == 0) begin
				report_mismatch("output word with nothing pending", 1, 0);
			end else begin
				want = blended_q.pop_front();
				if (out_word.out_ch0 !== want.out_ch0)
					report_mismatch("out_ch0", out_word.out_ch0, want.out_ch0);
				if (out_word.out_ch1 !== want.out_ch1)
					report_mismatch("out_ch1", out_word.out_ch1, want.out_ch1);
				if (out_word.out_ch2 !== want.out_ch2)
					report_mismatch("out_ch2", out_word.out_ch2, want.out_ch2);
				if (out_word.out_ch3 !== want.out_ch3)
					report_mismatch("out_ch3", out_word.out_ch3, want.out_ch3);
				if (out_word.inside_window !== want.inside_window)
					report_mismatch("inside_window", out_word.inside_window,
						want.inside_window);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Registers come out of reset as an empty window: nothing lands inside
		pixel_q.push_back(make_pixel(0, 0, 8'h00, 8'hFF, 8'hFF));
		pixel_q.push_back(make_pixel(MAX_COORD, MAX_COORD, 8'hFF, 8'h00, 8'hFF));
		wait_drained();

		// Small window: columns 10..17, rows 20..23
		write_reg(REG_LEFT, CFG_W'(10));
		write_reg(REG_TOP, CFG_W'(20));
		write_reg(REG_WIDTH, CFG_W'(8));
		write_reg(REG_HEIGHT, CFG_W'(4));
		// Opaque overlay over black background, top-left corner
		pixel_q.push_back(make_pixel(10, 20, 8'h00, 8'hFF, 8'hFF));
		// Zero opacity at the bottom-right corner: background passes, still inside
		pixel_q.push_back(make_pixel(17, 23, 8'hFF, 8'h00, 8'h00));
		// One step outside each edge
		pixel_q.push_back(make_pixel(9, 20, 8'h12, 8'hED, 8'h80));
		pixel_q.push_back(make_pixel(18, 20, 8'h12, 8'hED, 8'h80));
		pixel_q.push_back(make_pixel(10, 19, 8'h12, 8'hED, 8'h80));
		pixel_q.push_back(make_pixel(10, 24, 8'h12, 8'hED, 8'h80));
		// Opaque black overlay over white; channel 3 stays at full
		pixel_q.push_back(make_pixel(17, 20, 8'hFF, 8'h00, 8'hFF));
		// Near-transparent and near-opaque with alternating bit patterns
		pixel_q.push_back(make_pixel(13, 21, 8'hAA, 8'h55, 8'h01));
		pixel_q.push_back(make_pixel(14, 22, 8'h55, 8'hAA, 8'hFE));
		pixel_q.push_back(make_pixel(12, 21, 8'h80, 8'h7F, 8'h80));
		pixel_q.push_back(make_pixel(11, 20, 8'hFF, 8'hFF, 8'h7F));
		// Raster extremes, both far outside
		pixel_q.push_back(make_pixel(MAX_COORD, MAX_COORD, 8'hFF, 8'hFF, 8'hFF));
		pixel_q.push_back(make_pixel(0, 0, 8'h00, 8'h00, 8'h00));
		wait_drained();

		// Most negative origin with a 2048 size: the window ends just left of column 0
		run_window(12'h800, 12'h800, 12'd2048, 12'd2048, RAND_PIXELS, 15);
		// Single pixel at the far corner of the raster
		run_window(12'h7FF, 12'h7FF, 12'd1, 12'd1, RAND_PIXELS, 35);
		// Whole raster inside, no idling on either side
		run_window(12'd0, 12'd0, 12'd2048, 12'd2048, RAND_PIXELS, 0);
		// Sizes above range are taken as written
		run_window(CFG_W'(-5), CFG_W'(-3), 12'hFFF, 12'hFFF, RAND_PIXELS, 15);
		// Window hanging off the top-left corner
		run_window(CFG_W'(-4), CFG_W'(-4), CFG_W'(6), CFG_W'(6), RAND_PIXELS, 35);
		// Fully random register contents
		run_window(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
			RAND_PIXELS, 15);
		run_window(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
			RAND_PIXELS, 35);
		run_window(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
			RAND_PIXELS, 0);
		// Last stretch at full rate with no gaps and no stalls
		run_window(CFG_W'(100), CFG_W'(50), CFG_W'(64), CFG_W'(32), RAND_PIXELS, 0);

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
